@@ hdl/psrb_pkg.sv @@
package psrb_pkg;

  localparam int ADDR_W = 32;
  localparam int CFG_W  = 16;
  localparam int TIMER_W = 16;

  localparam logic [15:0] THRESHOLD_RESET = 16'd40;
  localparam logic [15:0] WINDOW_RESET    = 16'd1;

  typedef enum logic {
    REQ_PACKET = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_t;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_WINDOW    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [ADDR_W-1:0] src_addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] blocked_addr;
    logic              stored;
    logic              last;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOOKUP,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [ADDR_W-1:0] key;
    logic              any_hit;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HEAD,
    ST_BREAD,
    ST_BCMP,
    ST_REPORT,
    ST_FLUSH
  } state_t;

endpackage

@@ hdl/psrb_cell.sv @@
module psrb_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  psrb_pkg::cell_ctl_t         ctl,
  input  logic                        slot_valid,
  input  logic                        slot_free,
  input  logic [psrb_pkg::ADDR_W-1:0] nb_addr,
  input  logic [COUNT_BITS-1:0]       nb_count,
  output logic                        hit,
  output logic [psrb_pkg::ADDR_W-1:0] addr,
  output logic [COUNT_BITS-1:0]       count
);
  import psrb_pkg::*;

  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  assign hit   = slot_valid && (addr_r == ctl.key);
  assign addr  = addr_r;
  assign count = count_r;

  always_comb begin
    addr_nxt  = addr_r;
    count_nxt = count_r;
    case (ctl.op)
      CELL_LOOKUP: begin
        if (hit) begin
          if (count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end
        end else if (!ctl.any_hit && slot_free) begin
          addr_nxt  = ctl.key;
          count_nxt = COUNT_BITS'(1);
        end
      end
      CELL_SHIFT: begin
        addr_nxt  = nb_addr;
        count_nxt = nb_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    count_r <= count_nxt;
  end

endmodule

@@ hdl/per_source_rate_blocker_top.sv @@
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | psrb_pkg::in_t  (req_type, src_addr)
// out_     | output    | out_valid/out_stall| psrb_pkg::out_t (blocked_addr, stored, last)
// cfg_     | input     | cfg_we             | cfg_idx, cfg_wdata (16 bit)
//
// A tick is taken in ST_IDLE; a packet is accepted, then does one parallel compare in the cell
// row (ST_LOOKUP). A window-closing packet adds a scan of the source row ending in ST_FLUSH,
// one cell per cycle while sources are not over threshold; each source over it adds ST_BREAD
// and ST_BCMP per blocked-list entry searched (one memory port), then ST_REPORT if reported.
// rst_n is synchronous: it clears fill counts, timer and out_valid, and presets the registers.
// in_stall is high from a packet's accept until its scan is done; out_stall holds the scan.
module per_source_rate_blocker_top #(
  parameter int COUNT_ENTRIES = 64,
  parameter int BLOCK_ENTRIES = 256,
  parameter int COUNT_BITS    = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  psrb_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output psrb_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  psrb_pkg::cfg_idx_t         cfg_idx,
  input  logic [psrb_pkg::CFG_W-1:0] cfg_wdata
);
  import psrb_pkg::*;

  localparam int FILL_W = $clog2(COUNT_ENTRIES + 1);
  localparam int BF_W   = $clog2(BLOCK_ENTRIES + 1);
  localparam int BA_W   = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    key_r;
  logic [FILL_W-1:0]    fill_r;
  logic [FILL_W-1:0]    scan_left_r;
  logic [TIMER_W-1:0]   ticks_r;
  logic [CFG_W-1:0]     thr_r;
  logic [CFG_W-1:0]     win_r;
  logic [BF_W-1:0]      bfill_r;
  logic [BF_W-1:0]      bidx_r;
  logic [ADDR_W-1:0]    blk_rd_r;
  logic                 pend_valid_r;
  logic [ADDR_W-1:0]    pend_addr_r;
  logic                 pend_stored_r;
  logic                 out_valid_r;
  out_t                 out_r;
  logic [ADDR_W-1:0]    blk_mem [BLOCK_ENTRIES];

  cell_ctl_t             ctl;
  logic [COUNT_ENTRIES-1:0] hit;
  logic [ADDR_W-1:0]     cell_addr  [COUNT_ENTRIES];
  logic [COUNT_BITS-1:0] cell_count [COUNT_ENTRIES];

  logic       in_acc;
  logic       out_free;
  logic       advance;
  logic       out_load;
  logic       out_last;
  logic       report;
  logic       mem_rd;
  logic       head_over;
  logic       room;
  logic       any_hit;
  logic       ins;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign any_hit   = |hit;
  assign ins       = !any_hit && (fill_r < FILL_W'(COUNT_ENTRIES));
  assign head_over = CMP_W'(cell_count[0]) > CMP_W'(thr_r);
  assign room      = bfill_r < BF_W'(BLOCK_ENTRIES);

  assign ctl = '{op: (state_r == ST_LOOKUP) ? CELL_LOOKUP : (advance ? CELL_SHIFT : CELL_HOLD),
                 key: key_r,
                 any_hit: any_hit};

  for (genvar i = 0; i < COUNT_ENTRIES; i++) begin : g_cell
    logic [ADDR_W-1:0]     nb_addr;
    logic [COUNT_BITS-1:0] nb_count;
    if (i == COUNT_ENTRIES - 1) begin : g_tail
      assign nb_addr  = '0;
      assign nb_count = '0;
    end else begin : g_link
      assign nb_addr  = cell_addr[i+1];
      assign nb_count = cell_count[i+1];
    end
    psrb_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot_valid (FILL_W'(i) < fill_r),
      .slot_free  (fill_r == FILL_W'(i)),
      .nb_addr    (nb_addr),
      .nb_count   (nb_count),
      .hit        (hit[i]),
      .addr       (cell_addr[i]),
      .count      (cell_count[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    advance   = 1'b0;
    out_load  = 1'b0;
    out_last  = 1'b0;
    report    = 1'b0;
    mem_rd    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.req_type == REQ_PACKET) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = (ticks_r >= win_r) ? ST_HEAD : ST_IDLE;
      end
      ST_HEAD: begin
        if (scan_left_r == '0) begin
          state_nxt = ST_FLUSH;
        end else if (head_over) begin
          state_nxt = ST_BREAD;
        end else begin
          advance = 1'b1;
        end
      end
      ST_BREAD: begin
        if (bidx_r == bfill_r) begin
          state_nxt = ST_REPORT;
        end else begin
          mem_rd    = 1'b1;
          state_nxt = ST_BCMP;
        end
      end
      ST_BCMP: begin
        if (blk_rd_r == cell_addr[0]) begin
          advance   = 1'b1;
          state_nxt = ST_HEAD;
        end else begin
          state_nxt = ST_BREAD;
        end
      end
      ST_REPORT: begin
        if (!pend_valid_r || out_free) begin
          report    = 1'b1;
          advance   = 1'b1;
          out_load  = pend_valid_r;
          state_nxt = ST_HEAD;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load  = 1'b1;
          out_last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      ticks_r      <= '0;
      thr_r        <= THRESHOLD_RESET;
      win_r        <= WINDOW_RESET;
      bfill_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      scan_left_r  <= '0;
      bidx_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_THRESHOLD: thr_r <= cfg_wdata;
          CFG_WINDOW:    win_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_acc && in_data.req_type == REQ_TICK && ticks_r != '1) begin
        ticks_r <= ticks_r + 1'b1;
      end
      if (state_r == ST_LOOKUP) begin
        fill_r      <= fill_r + FILL_W'(ins);
        scan_left_r <= fill_r + FILL_W'(ins);
      end else if (advance) begin
        scan_left_r <= scan_left_r - 1'b1;
      end
      if (state_r == ST_HEAD) begin
        bidx_r <= '0;
      end else if (state_r == ST_BCMP) begin
        bidx_r <= bidx_r + 1'b1;
      end
      if (report) begin
        pend_valid_r <= 1'b1;
        if (room) begin
          bfill_r <= bfill_r + 1'b1;
        end
      end
      if (state_r == ST_FLUSH && state_nxt == ST_IDLE) begin
        pend_valid_r <= 1'b0;
        fill_r       <= '0;
        ticks_r      <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      key_r <= in_data.src_addr;
    end
    if (report) begin
      pend_addr_r   <= cell_addr[0];
      pend_stored_r <= room;
      if (room) begin
        blk_mem[bfill_r[BA_W-1:0]] <= cell_addr[0];
      end
    end
    if (mem_rd) begin
      blk_rd_r <= blk_mem[bidx_r[BA_W-1:0]];
    end
    if (out_load) begin
      out_r.blocked_addr <= pend_addr_r;
      out_r.stored       <= pend_stored_r;
      out_r.last         <= out_last;
    end
  end

endmodule

@@ hdl/psrb_check.sv @@
module psrb_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input psrb_pkg::in_t              in_data,
  input logic                       out_valid,
  input logic                       out_stall,
  input psrb_pkg::out_t             out_data
);
  import psrb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_packet_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type == REQ_PACKET |=> in_stall)
    else $error("input taken during packet lookup");

  a_tick_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type == REQ_TICK |=> !in_stall)
    else $error("tick left the input stalled");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input open while a report is still to follow");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind per_source_rate_blocker_top psrb_check u_psrb_check (.*);

@@ bench/tb_per_source_rate_blocker_top.sv @@
module tb_per_source_rate_blocker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psrb_pkg::*;

  localparam int COUNT_ENTRIES  = 64;
  localparam int BLOCK_ENTRIES  = 256;
  localparam int COUNT_BITS     = 16;
  localparam int WATCHDOG_LIMIT = 150000;

  class block_report_sb;
    logic [ADDR_W-1:0]     src_addrs[COUNT_ENTRIES];
    logic [COUNT_BITS-1:0] src_counts[COUNT_ENTRIES];
    int                    src_fill;
    logic [ADDR_W-1:0]     blocked_addrs[BLOCK_ENTRIES];
    int                    blocked_fill;
    logic [TIMER_W-1:0]    ticks;
    logic [CFG_W-1:0]      threshold;
    logic [CFG_W-1:0]      window;
    out_t                  reports_due[$];
    int                    errors;
    int                    n_packets;
    int                    n_ticks;
    int                    n_windows;
    int                    n_reports;
    int                    n_unstored;
    int                    max_burst;

    function new();
      src_fill     = 0;
      blocked_fill = 0;
      ticks        = '0;
      threshold    = THRESHOLD_RESET;
      window       = WINDOW_RESET;
      errors       = 0;
      n_packets    = 0;
      n_ticks      = 0;
      n_windows    = 0;
      n_reports    = 0;
      n_unstored   = 0;
      max_burst    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
      if (idx == CFG_THRESHOLD) threshold = value;
      else if (idx == CFG_WINDOW) window = value;
    endfunction

    function bit is_blocked(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < blocked_fill; i++) begin
        if (blocked_addrs[i] == addr) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_item(in_t item);
      logic [ADDR_W-1:0] addr;
      bit                found;
      out_t              rep;
      out_t              burst[$];

      if (item.req_type == REQ_TICK) begin
        n_ticks++;
        if (ticks != '1) ticks++;
        return;
      end
      n_packets++;
      addr  = item.src_addr;
      found = 1'b0;
      for (int i = 0; i < src_fill && !found; i++) begin
        if (src_addrs[i] == addr) begin
          found = 1'b1;
          if (src_counts[i] != '1) src_counts[i]++;
        end
      end
      if (!found && src_fill < COUNT_ENTRIES) begin
        src_addrs[src_fill]  = addr;
        src_counts[src_fill] = COUNT_BITS'(1);
        src_fill++;
      end
      if (ticks >= window) begin
        n_windows++;
        for (int i = 0; i < src_fill; i++) begin
          if (src_counts[i] > threshold && !is_blocked(src_addrs[i])) begin
            rep.blocked_addr = src_addrs[i];
            rep.stored       = (blocked_fill < BLOCK_ENTRIES);
            rep.last         = 1'b0;
            if (rep.stored) begin
              blocked_addrs[blocked_fill] = src_addrs[i];
              blocked_fill++;
            end else begin
              n_unstored++;
            end
            burst.push_back(rep);
          end
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        if (burst.size() > max_burst) max_burst = burst.size();
        foreach (burst[i]) reports_due.push_back(burst[i]);
        n_reports += burst.size();
        src_fill = 0;
        ticks    = '0;
      end
    endfunction

    function void match_report(out_t got);
      out_t want;
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %h/%b/%b", $time,
                 got.blocked_addr, got.stored, got.last);
        errors++;
        return;
      end
      want = reports_due.pop_front();
      if (got.blocked_addr !== want.blocked_addr) begin
        $display("%0t: blocked_addr expected %h got %h", $time,
                 want.blocked_addr, got.blocked_addr);
        errors++;
      end
      if (got.stored !== want.stored) begin
        $display("%0t: stored expected %b got %b (addr %h)", $time,
                 want.stored, got.stored, want.blocked_addr);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b got %b (addr %h)", $time,
                 want.last, got.last, want.blocked_addr);
        errors++;
      end
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    function int drain_cycles();
      return COUNT_ENTRIES * (1 + 2 * blocked_fill) + 64;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_idx = CFG_THRESHOLD;
  logic [CFG_W-1:0] cfg_wdata = '0;

  block_report_sb sb;
  int send_idle_pct = 27;
  int recv_idle_pct = 80;
  int send_quiet = 0;
  int hold_request = 0;
  int hold_left = 0;
  int recv_quiet = 0;
  int idle_cycles = 0;

  per_source_rate_blocker_top #(
    .COUNT_ENTRIES(COUNT_ENTRIES),
    .BLOCK_ENTRIES(BLOCK_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_quiet > 0) begin
      recv_quiet--;
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) < 3) recv_quiet = $urandom_range(10, 40);
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        sb.take_item(in_data);
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        sb.match_report(out_data);
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input req_type_t kind, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    if (send_quiet > 0) begin
      send_quiet--;
    end else begin
      if ($urandom_range(0, 99) < 10) send_quiet = $urandom_range(4, 12);
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, src_addr: addr};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_packet(input logic [ADDR_W-1:0] addr);
    send_item(REQ_PACKET, addr);
  endtask

  task automatic send_tick(input logic [ADDR_W-1:0] addr);
    send_item(REQ_TICK, addr);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (sb.drain_cycles()) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] win);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_idx   <= CFG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_THRESHOLD, thr);
    sb.write_reg(CFG_WINDOW, win);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic run_random(input int n_items);
    logic [ADDR_W-1:0] pool[8];
    int                pool_n;
    int                roll;
    pool_n = 1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        pool_n = $urandom_range(1, 8);
        for (int k = 0; k < 8; k++) pool[k] = $urandom;
      end
      roll = $urandom_range(0, 99);
      if (roll < 15) send_tick($urandom);
      else if (roll < 27) send_packet($urandom);
      else send_packet(pool[$urandom_range(0, pool_n - 1)]);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: window of one tick, count must exceed 40
    set_idle(27, 80);
    send_tick(32'hFFFF_FFFF);
    send_packet(32'h1234_5678);
    send_packet(32'h1234_5678);

    set_config(16'd0, 16'd1);
    send_packet(32'h0000_0000);
    send_packet(32'hFFFF_FFFF);
    send_packet(32'hFFFF_FFFF);
    send_tick(32'h0000_0000);
    send_packet(32'h0000_0000);
    send_packet(32'h0000_0000);
    send_tick(32'h5555_AAAA);
    send_packet(32'h0000_0000);

    set_config(16'hFFFF, 16'd0);
    send_packet(32'hA5A5_5A5A);
    send_packet(32'hA5A5_5A5A);

    set_config(16'd0, 16'd0);
    send_packet(32'h8000_0001);
    send_tick(32'h7FFF_FFFE);
    send_packet(32'h7FFF_FFFE);

    set_config(16'd2, 16'hFFFF);
    send_packet(32'hC0A8_0001);
    send_packet(32'hC0A8_0001);
    send_packet(32'hC0A8_0001);
    send_tick(32'h0);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) set_idle(80, 27);
      if (phase == 4) set_idle(0, 0);
      set_config(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 4)));
      run_random(24);

      if (phase == 3) begin
        // overflow the source table, then close the window while the receiver holds off
        set_config(16'd0, 16'd0);
        send_packet($urandom);
        set_config(16'd0, 16'd3);
        for (int i = 0; i < 70; i++) send_packet($urandom);
        repeat (3) send_tick($urandom);
        hold_request = 400;
        send_packet($urandom);
        run_random(10);
      end
    end

    wait_idle();
    $display("Run covered %0d packets and %0d ticks, %0d windows closed.",
             sb.n_packets, sb.n_ticks, sb.n_windows);
    $display("%0d block reports, %0d with the list full, up to %0d from one packet.",
             sb.n_reports, sb.n_unstored, sb.max_burst);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
